>>> rtl/lmf_pkg.sv
// Shared types and constants for the 3x3 Laplacian mirror filter.
package lmf_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 11;
  localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

  // Per-item control that rides along with a pixel column.
  typedef struct packed {
    logic emit;
    logic frame_end;
    logic up_refl;
    logic down_refl;
    logic left_refl;
    logic right_refl;
  } ctl_t;

endpackage

>>> rtl/lmf_stream_if.sv
// Valid/ready channel carrying one payload word per transaction.
interface lmf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lmf_line_buf.sv
// Two line-buffer memories (older and newer row) with same-address forwarding.
module lmf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [lmf_pkg::PIX_W-1:0] wr_old,
  input  logic [lmf_pkg::PIX_W-1:0] wr_new,
  output logic [lmf_pkg::PIX_W-1:0] rd_old,
  output logic [lmf_pkg::PIX_W-1:0] rd_new
);

  logic [lmf_pkg::PIX_W-1:0] old_mem [DEPTH];
  logic [lmf_pkg::PIX_W-1:0] new_mem [DEPTH];

  logic [lmf_pkg::PIX_W-1:0] q_old_r, q_new_r;
  logic [lmf_pkg::PIX_W-1:0] fwd_old_r, fwd_new_r;
  logic                      fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      old_mem[wr_addr] <= wr_old;
      new_mem[wr_addr] <= wr_new;
    end
  end

  // Read data and the bypass hold while the reading stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_old_r   <= old_mem[rd_addr];
      q_new_r   <= new_mem[rd_addr];
      fwd_r     <= wr_en && (wr_addr == rd_addr);
      fwd_old_r <= wr_old;
      fwd_new_r <= wr_new;
    end
  end

  assign rd_old = fwd_r ? fwd_old_r : q_old_r;
  assign rd_new = fwd_r ? fwd_new_r : q_new_r;

endmodule

>>> rtl/lmf_window.sv
// 3x3 window shift register, Laplacian kernel with mirrored borders, output register.
module lmf_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [lmf_pkg::PIX_W-1:0] col_top,
  input  logic [lmf_pkg::PIX_W-1:0] col_mid,
  input  logic [lmf_pkg::PIX_W-1:0] col_bot,
  input  lmf_pkg::ctl_t             ctl,
  output logic                      s2_free,
  lmf_stream_if.source              out_ch
);

  logic [lmf_pkg::PIX_W-1:0] win_r [9];
  logic                      s2_v_r;
  lmf_pkg::ctl_t             s2_ctl_r;
  logic                      out_v_r;
  lmf_pkg::out_item_t        out_r;

  logic                          out_en, s2_go;
  logic [lmf_pkg::PIX_W-1:0]     up, down, left, right;
  logic signed [lmf_pkg::SUM_W-1:0] sum;
  logic [lmf_pkg::SUM_W-1:0]     abs_sum;
  lmf_pkg::out_item_t            result;

  assign out_en  = !out_v_r || out_ch.ready;
  assign s2_go   = s2_v_r && (!s2_ctl_r.emit || out_en);
  assign s2_free = !s2_v_r || s2_go;

  // Window columns: [0..2] oldest, [6..8] newest; rows top/mid/bot.
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < 6; i++) win_r[i] <= win_r[i+3];
      win_r[6] <= col_top;
      win_r[7] <= col_mid;
      win_r[8] <= col_bot;
      s2_ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (shift) begin
      s2_v_r <= 1'b1;
    end else if (s2_go) begin
      s2_v_r <= 1'b0;
    end
  end

  // Centre sits at win_r[4]; missing neighbours take the reflected pixel.
  always_comb begin
    up    = s2_ctl_r.up_refl    ? win_r[5] : win_r[3];
    down  = s2_ctl_r.down_refl  ? win_r[3] : win_r[5];
    left  = s2_ctl_r.left_refl  ? win_r[7] : win_r[1];
    right = s2_ctl_r.right_refl ? win_r[1] : win_r[7];
    sum   = $signed({3'b000, up}) + $signed({3'b000, down})
          + $signed({3'b000, left}) + $signed({3'b000, right})
          - $signed({1'b0, win_r[4], 2'b00});
    abs_sum = sum[lmf_pkg::SUM_W-1] ? lmf_pkg::SUM_W'(-sum) : lmf_pkg::SUM_W'(sum);
    result.magnitude = (abs_sum > lmf_pkg::SUM_W'(lmf_pkg::SAT_MAX)) ?
                       lmf_pkg::SAT_MAX : abs_sum[lmf_pkg::PIX_W-1:0];
    result.frame_end = s2_ctl_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_go && s2_ctl_r.emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_ctl_r.emit) begin
      out_r <= result;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_ctl_r.emit && out_v_r && !out_ch.ready |=> s2_v_r && $stable(win_r[4]))
    else $error("window stage lost a stalled result");

  a_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_ctl_r.emit && !s2_go |-> out_v_r)
    else $error("window stage stalled with an empty output register");

  a_shift_free: assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> s2_free)
    else $error("window shifted over an item still in use");

endmodule

>>> rtl/laplacian_3x3_mirror_filter.sv
// Top level: configuration, frame position counters, line-buffer stage, window stage.
// Streams an 8-bit grey frame in raster order, followed by frame_width+1 flush
// transactions, and returns |up+down+left+right-4*centre| saturated to 255 with
// mirrored borders; the result for pixel k comes out on input k+frame_width+1 and
// frame_end marks the last one. One pixel per clock is sustained unless the output
// stalls; a result passes the line-buffer memory read, window shift and output
// register, and up to three transactions are held in flight while the output stalls.
// The line buffers hold no reset state and need no clearing pass: rows
// from before the current frame never reach a result. A configuration write
// restarts the frame position at zero and should be issued with the block idle.
module laplacian_3x3_mirror_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  lmf_stream_if.sink   in_ch,
  lmf_stream_if.sink   cfg_ch,
  lmf_stream_if.source out_ch
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int OROW_W  = $clog2(MAX_HEIGHT);
  localparam int IROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int RST_WM1 = ((MAX_WIDTH < 512) ? MAX_WIDTH : 512) - 1;
  localparam int RST_HM1 = ((MAX_HEIGHT < 512) ? MAX_HEIGHT : 512) - 1;

  logic [CW-1:0]     wm1_r;
  logic [OROW_W-1:0] hm1_r;
  logic [CW-1:0]     in_col_r, out_col_r;
  logic [IROW_W-1:0] in_row_r;
  logic [OROW_W-1:0] out_row_r;

  logic                      s1_v_r;
  logic [CW-1:0]             s1_col_r;
  logic [lmf_pkg::PIX_W-1:0] s1_p_r;
  lmf_pkg::ctl_t             s1_ctl_r;

  logic                      acc, cfg_acc, s1_go, s2_free;
  logic                      last_in_col, last_ocol, last_orow;
  logic [lmf_pkg::PIX_W-1:0] pix;
  lmf_pkg::ctl_t             ctl;
  logic [lmf_pkg::FW_W-1:0]  fw_req;
  logic [lmf_pkg::FH_W-1:0]  fh_req;
  logic [CW-1:0]             wm1_cfg;
  logic [OROW_W-1:0]         hm1_cfg;
  logic [lmf_pkg::PIX_W-1:0] above2, above1;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign acc          = in_ch.valid && in_ch.ready;
  assign s1_go        = s1_v_r && s2_free;
  assign in_ch.ready  = !s1_v_r || s1_go;
  assign pix          = in_ch.data.flush ? '0 : in_ch.data.pixel;

  // Sizes use the low FW_W/FH_W value bits, then clamp to [2, MAX]; stored as size minus one.
  assign fw_req  = cfg_ch.data.value[lmf_pkg::FW_W-1:0];
  assign fh_req  = cfg_ch.data.value[lmf_pkg::FH_W-1:0];
  assign wm1_cfg = (fw_req < lmf_pkg::FW_W'(2)) ? CW'(1) :
                   (fw_req > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) :
                   CW'(fw_req - lmf_pkg::FW_W'(1));
  assign hm1_cfg = (fh_req < lmf_pkg::FH_W'(2)) ? OROW_W'(1) :
                   (fh_req > MAX_HEIGHT) ? OROW_W'(MAX_HEIGHT - 1) :
                   OROW_W'(fh_req - lmf_pkg::FH_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r <= CW'(RST_WM1);
      hm1_r <= OROW_W'(RST_HM1);
    end else if (cfg_acc) begin
      unique case (cfg_ch.data.index)
        lmf_pkg::REG_FRAME_WIDTH:  wm1_r <= wm1_cfg;
        lmf_pkg::REG_FRAME_HEIGHT: hm1_r <= hm1_cfg;
      endcase
    end
  end

  always_comb begin
    last_in_col    = (in_col_r == wm1_r);
    last_ocol      = (out_col_r == wm1_r);
    last_orow      = (out_row_r == hm1_r);
    ctl.emit       = (in_row_r >= IROW_W'(2)) ||
                     ((in_row_r == IROW_W'(1)) && (in_col_r != '0));
    ctl.frame_end  = ctl.emit && last_orow && last_ocol;
    ctl.up_refl    = (out_row_r == '0);
    ctl.down_refl  = last_orow;
    ctl.left_refl  = (out_col_r == '0);
    ctl.right_refl = last_ocol;
  end

  // Input steps per item, output per emitting item; frame end or config clears both.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_acc) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (acc) begin
      if (ctl.frame_end) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        in_col_r <= last_in_col ? '0 : in_col_r + 1'b1;
        if (last_in_col) in_row_r <= in_row_r + 1'b1;
        if (ctl.emit) begin
          out_col_r <= last_ocol ? '0 : out_col_r + 1'b1;
          if (last_ocol) out_row_r <= out_row_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r <= in_col_r;
      s1_p_r   <= pix;
      s1_ctl_r <= ctl;
    end
  end

  // Column rotates down: newer row moves to older, incoming pixel to newer.
  lmf_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (in_col_r),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_old  (above1),
    .wr_new  (s1_p_r),
    .rd_old  (above2),
    .rd_new  (above1)
  );

  lmf_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (s1_go),
    .col_top (above2),
    .col_mid (above1),
    .col_bot (s1_p_r),
    .ctl     (s1_ctl_r),
    .s2_free (s2_free),
    .out_ch  (out_ch)
  );

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r <= wm1_r)
    else $error("input column beyond frame width");

  a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_col_r <= wm1_r) && (out_row_r <= hm1_r))
    else $error("output position outside frame");

  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ctl.frame_end |=> (in_col_r == '0) && (in_row_r == '0) && (out_row_r == '0))
    else $error("frame end did not restart position counters");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_free |=> s1_v_r && $stable(s1_col_r) && $stable(s1_p_r))
    else $error("line-buffer stage dropped a stalled transaction");

endmodule
